// ===== hdl/bilinear_image_scaler_assert.svh =====
// Assertion macros for the bilinear image scaler checker.
// Depends on nothing; included by the checker file.
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH

// same-cycle implication
`define BIS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bis_pkg.sv =====
// Shared types and constants of the bilinear image scaler.
// No dependencies; used by the top level and its checker.
package bis_pkg;

   localparam int SIZE_W  = 10;               // size registers
   localparam int COORD_W = 9;                // request coordinates
   localparam int CHAN_W  = 8;
   localparam int NUM_CH  = 4;
   localparam int CCNT_W  = 3;
   localparam int LIM_W   = 13;               // holds the largest image size
   localparam int FRAC_W  = 8;                // weight fraction bits
   localparam int QUO_W   = SIZE_W + FRAC_W;  // floor and fraction together
   localparam int NUM_W   = 2 * SIZE_W + 1;
   localparam int DEN_W   = SIZE_W + 1;
   localparam int WT_W    = FRAC_W + 1;
   localparam int CNT_W   = $clog2(QUO_W);
   localparam int CSR_AW  = 5;

   localparam logic KIND_STORE   = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_DST_WIDTH   = 3'd2;
   localparam logic [2:0] REG_DST_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_CHAN_COUNT  = 3'd4;

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [CHAN_W-1:0]  in_ch0;
      logic [CHAN_W-1:0]  in_ch1;
      logic [CHAN_W-1:0]  in_ch2;
      logic [CHAN_W-1:0]  in_ch3;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_ch0;
      logic [CHAN_W-1:0] out_ch1;
      logic [CHAN_W-1:0] out_ch2;
      logic [CHAN_W-1:0] out_ch3;
   } rsp_type;

endpackage

// ===== hdl/bis_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bilinear_image_scaler.sv =====
// Bilinear image scaler top level: source pixel store and half-pixel-centre resampler.
// Depends on bis_pkg and bis_ram. A store request (kind 0) writes one 32-bit source pixel
// and leaves busy low. A compute request (kind 1) holds busy high while it runs, and its
// result strobes on rsp_valid for one cycle as busy falls: the source position and weights
// come from an 18-step bit-serial divider (both axes side by side), then the four
// neighbours are read one per cycle from the single-port pixel memory. The receiver cannot
// stall, so rsp_data must be taken while rsp_valid is high. Requests outside the configured
// sizes are dropped without a result. The pixel memory is not cleared; reading a pixel
// never written gives undefined data.
module bilinear_image_scaler #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  bis_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output bis_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bis_pkg::CSR_AW-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   import bis_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [LIM_W-1:0] LIM_WIDTH  = LIM_W'(MAX_WIDTH);
   localparam logic [LIM_W-1:0] LIM_HEIGHT = LIM_W'(MAX_HEIGHT);

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_DIV, S_IDX, S_FETCH, S_DRAIN, S_FIN
   } state_type;

   function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                  input logic [LIM_W-1:0]  lim);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (LIM_W'(v) > lim) begin
         r = lim[SIZE_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]  src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [CCNT_W-1:0]  nch_ff;

   // datapath, axis 0 is x and axis 1 is y
   logic [COORD_W-1:0] pos_ff [2];
   logic [COORD_W-1:0] pos_in [2];
   logic               neg_ff [2];
   logic               neg_in [2];
   logic [DEN_W-1:0]   rem_ff [2];
   logic [DEN_W-1:0]   rem_in [2];
   logic [QUO_W-1:0]   quo_ff [2];
   logic [QUO_W-1:0]   quo_in [2];
   logic [SIZE_W-1:0]  idx0_ff [2];
   logic [SIZE_W-1:0]  idx0_in [2];
   logic [SIZE_W-1:0]  idx1_ff [2];
   logic [SIZE_W-1:0]  idx1_in [2];
   logic [WT_W-1:0]    wt0_ff [2];
   logic [WT_W-1:0]    wt0_in [2];
   logic [WT_W-1:0]    wt1_ff [2];
   logic [WT_W-1:0]    wt1_in [2];
   logic [16:0]        weight_ff, weight_in;
   logic [23:0]        acc_ff [NUM_CH];
   logic [23:0]        acc_in [NUM_CH];
   rsp_type            rsp_ff, rsp_in;

   logic [SIZE_W-1:0]  size_s [2];
   logic [SIZE_W-1:0]  size_d [2];
   logic [DEN_W-1:0]   den [2];
   logic [19:0]        prod [2];
   logic [NUM_W:0]     num [2];
   logic [NUM_W:0]     num_adj [2];
   logic [DEN_W:0]     trial [2];
   logic               ge [2];
   logic [SIZE_W-1:0]  fl [2];

   logic               cfg_wr, store_ok, compute_ok;
   logic [SIZE_W-1:0]  fx_sel, fy_sel;
   logic [AW-1:0]      st_addr, rd_addr, ram_addr;
   logic               ram_we;
   logic [31:0]        ram_wdata, ram_rdata;
   logic               acc_en;
   logic [24:0]        rounded [NUM_CH];
   logic [CHAN_W-1:0]  ch_val [NUM_CH];

   assign size_s[0] = sat_size(src_w_ff, LIM_WIDTH);
   assign size_s[1] = sat_size(src_h_ff, LIM_HEIGHT);
   assign size_d[0] = sat_size(dst_w_ff, LIM_WIDTH);
   assign size_d[1] = sat_size(dst_h_ff, LIM_HEIGHT);

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;

   // configuration port
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[4:2])
         REG_SRC_WIDTH:  prdata = 32'(src_w_ff);
         REG_SRC_HEIGHT: prdata = 32'(src_h_ff);
         REG_DST_WIDTH:  prdata = 32'(dst_w_ff);
         REG_DST_HEIGHT: prdata = 32'(dst_h_ff);
         REG_CHAN_COUNT: prdata = 32'(nch_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SIZE_W'(512);
         src_h_ff <= SIZE_W'(512);
         dst_w_ff <= SIZE_W'(512);
         dst_h_ff <= SIZE_W'(512);
         nch_ff   <= CCNT_W'(4);
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_SRC_WIDTH:  src_w_ff <= pwdata[SIZE_W-1:0];
            REG_SRC_HEIGHT: src_h_ff <= pwdata[SIZE_W-1:0];
            REG_DST_WIDTH:  dst_w_ff <= pwdata[SIZE_W-1:0];
            REG_DST_HEIGHT: dst_h_ff <= pwdata[SIZE_W-1:0];
            REG_CHAN_COUNT: nch_ff   <= pwdata[CCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // request decode
   assign store_ok = start && !busy && (req_data.kind == KIND_STORE)
                     && (SIZE_W'(req_data.pos_x) < size_s[0])
                     && (SIZE_W'(req_data.pos_y) < size_s[1]);
   assign compute_ok = start && !busy && (req_data.kind == KIND_COMPUTE)
                       && (SIZE_W'(req_data.pos_x) < size_d[0])
                       && (SIZE_W'(req_data.pos_y) < size_d[1]);

   // pixel memory
   assign fx_sel  = k_ff[0] ? idx1_ff[0] : idx0_ff[0];
   assign fy_sel  = k_ff[1] ? idx1_ff[1] : idx0_ff[1];
   assign st_addr = AW'(int'(req_data.pos_y) * MAX_WIDTH + int'(req_data.pos_x));
   assign rd_addr = AW'(int'(fy_sel) * MAX_WIDTH + int'(fx_sel));
   assign ram_addr  = (state_ff == S_IDLE) ? st_addr : rd_addr;
   assign ram_we    = store_ok;
   assign ram_wdata = {req_data.in_ch3, req_data.in_ch2, req_data.in_ch1, req_data.in_ch0};

   bis_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (compute_ok) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = S_DIV;
            cnt_in   = CNT_W'(QUO_W - 1);
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               state_in = S_IDX;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_IDX: begin
            state_in = S_FETCH;
            k_in     = '0;
         end
         S_FETCH: begin
            k_in = k_ff + 1'b1;
            if (k_ff == '1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_FIN;
         S_FIN: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // per-axis position: floor and weight from ((2d+1)*S - D) * 256 / (2*D)
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         den[a]     = {size_d[a], 1'b0};
         prod[a]    = 20'({pos_ff[a], 1'b1}) * 20'(size_s[a]);
         num[a]     = (NUM_W + 1)'(prod[a]) - (NUM_W + 1)'(size_d[a]);
         num_adj[a] = num[a][NUM_W] ? num[a] + (NUM_W + 1)'(den[a]) : num[a];
         trial[a]   = {rem_ff[a], quo_ff[a][QUO_W-1]};
         ge[a]      = trial[a] >= (DEN_W + 1)'(den[a]);
         fl[a]      = quo_ff[a][QUO_W-1:FRAC_W];

         pos_in[a]  = pos_ff[a];
         neg_in[a]  = neg_ff[a];
         rem_in[a]  = rem_ff[a];
         quo_in[a]  = quo_ff[a];
         idx0_in[a] = idx0_ff[a];
         idx1_in[a] = idx1_ff[a];
         wt0_in[a]  = wt0_ff[a];
         wt1_in[a]  = wt1_ff[a];

         unique case (state_ff)
            S_IDLE: pos_in[a] = (a == 0) ? req_data.pos_x : req_data.pos_y;
            S_PREP: begin
               neg_in[a] = num[a][NUM_W];
               rem_in[a] = num_adj[a][NUM_W-1:SIZE_W];
               quo_in[a] = {num_adj[a][SIZE_W-1:0], FRAC_W'(0)};
            end
            S_DIV: begin
               rem_in[a] = ge[a] ? DEN_W'(trial[a] - (DEN_W + 1)'(den[a]))
                                 : trial[a][DEN_W-1:0];
               quo_in[a] = {quo_ff[a][QUO_W-2:0], ge[a]};
            end
            S_IDX: begin
               idx0_in[a] = neg_ff[a] ? '0 : fl[a];
               if (neg_ff[a]) begin
                  idx1_in[a] = '0;
               end else if (fl[a] == size_s[a] - 1'b1) begin
                  idx1_in[a] = fl[a];
               end else begin
                  idx1_in[a] = fl[a] + 1'b1;
               end
               wt0_in[a] = WT_W'(256) - WT_W'(quo_ff[a][FRAC_W-1:0]);
               wt1_in[a] = WT_W'(quo_ff[a][FRAC_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   // blend: weight for the read being issued, products of the read returning
   assign weight_in = 17'(18'(k_ff[0] ? wt1_ff[0] : wt0_ff[0])
                         * 18'(k_ff[1] ? wt1_ff[1] : wt0_ff[1]));
   assign acc_en = ((state_ff == S_FETCH) && (k_ff != '0)) || (state_ff == S_DRAIN);

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (state_ff == S_IDX) begin
            acc_in[c] = '0;
         end else if (acc_en) begin
            acc_in[c] = acc_ff[c] + 24'(ram_rdata[CHAN_W*c +: CHAN_W]) * 24'(weight_ff);
         end else begin
            acc_in[c] = acc_ff[c];
         end
         rounded[c] = 25'(acc_ff[c]) + 25'd32768;
         if (CCNT_W'(c) >= nch_ff) begin
            ch_val[c] = '0;
         end else if (rounded[c][24:16] > 9'd255) begin
            ch_val[c] = '1;
         end else begin
            ch_val[c] = rounded[c][23:16];
         end
      end
      rsp_in = rsp_ff;
      if (state_ff == S_FIN) begin
         rsp_in.out_ch0 = ch_val[0];
         rsp_in.out_ch1 = ch_val[1];
         rsp_in.out_ch2 = ch_val[2];
         rsp_in.out_ch3 = ch_val[3];
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      idx0_ff   <= idx0_in;
      idx1_ff   <= idx1_in;
      wt0_ff    <= wt0_in;
      wt1_ff    <= wt1_in;
      weight_ff <= weight_in;
      acc_ff    <= acc_in;
   end

endmodule

// ===== hdl/bis_check.sv =====
// Port-level checker for the bilinear image scaler, bound to the top level.
// Depends on bis_pkg and bilinear_image_scaler_assert.svh.
`include "bilinear_image_scaler_assert.svh"

module bis_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input bis_pkg::req_type           req_data,
   input logic                       rsp_valid,
   input bis_pkg::rsp_type           rsp_data,
   input logic                       psel,
   input logic                       penable,
   input logic                       pwrite,
   input logic [bis_pkg::CSR_AW-1:0] paddr,
   input logic [31:0]                pwdata,
   input logic [31:0]                prdata,
   input logic                       pready
);

   import bis_pkg::*;

   localparam int RSP_LAT = 27;

   `BIS_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")
   `BIS_ASSERT_IMP(a_rsp_end, clock, reset, rsp_valid, (!busy && $past(busy)), "result not at end of compute")
   `BIS_ASSERT_NXT(a_store_free, clock, reset, (start && !busy && (req_data.kind == KIND_STORE)), !busy, "store request held busy")
   `BIS_ASSERT_IMP(a_rsp_latency, clock, reset, rsp_valid, $past(start && !busy && (req_data.kind == KIND_COMPUTE), RSP_LAT), "result without compute request")
   `BIS_ASSERT_IMP(a_busy_cause, clock, reset, $rose(busy), $past(start && (req_data.kind == KIND_COMPUTE)), "busy without compute request")

endmodule

bind bilinear_image_scaler bis_check u_bis_check (.*);

// ===== tb/bilinear_image_scaler_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bilinear image scaler: follows register writes and accepted requests,
// keeps its own copy of the source image, predicts each resampled pixel and compares it
// with rsp_data field by field. Depends on bis_pkg.
module bilinear_image_scaler_checker #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  bis_pkg::req_type           req_data,
   input  logic                       rsp_valid,
   input  bis_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bis_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   input  logic                       pready,
   output int                         fail_count,
   output int                         pending,
   output int                         results_checked
);

   typedef struct {
      int lo;
      int hi;
      int wt;
   } taps_type;

   logic [bis_pkg::SIZE_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
   logic [bis_pkg::CCNT_W-1:0] ccnt_reg;
   bit [31:0]                  source_copy [int];
   bis_pkg::rsp_type           expected_pixels [$];
   int                         errors = 0;
   int                         checked = 0;

   function automatic int size_in_use(logic [bis_pkg::SIZE_W-1:0] v, int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return int'(v);
   endfunction

   // neighbour indices and 8-bit weight along one axis, half-pixel centres
   function automatic taps_type axis_taps(int d, int s, int dd);
      longint n, den, fl;
      taps_type t;
      n = longint'(2 * d + 1) * s - dd;
      den = 2 * dd;
      if (n >= 0) fl = n / den;
      else fl = -1 - ((-n - 1) / den);
      t.wt = int'(((n - fl * den) * 256) / den);
      t.lo = (fl < 0) ? 0 : ((fl > s - 1) ? s - 1 : int'(fl));
      t.hi = (fl + 1 > s - 1) ? s - 1 : int'(fl + 1);
      return t;
   endfunction

   function automatic logic [31:0] read_pixel(int x, int y);
      int idx;
      idx = y * MAX_WIDTH + x;
      return source_copy.exists(idx) ? source_copy[idx] : 32'h0;
   endfunction

   function automatic bis_pkg::rsp_type resample_pixel(int x, int y);
      taps_type         tx, ty;
      logic [31:0]      p00, p01, p10, p11;
      int               nch, a, b, v, sh;
      logic [7:0]       ch [4];
      bis_pkg::rsp_type r;
      tx = axis_taps(x, size_in_use(src_w_reg, MAX_WIDTH), size_in_use(dst_w_reg, MAX_WIDTH));
      ty = axis_taps(y, size_in_use(src_h_reg, MAX_HEIGHT),
                     size_in_use(dst_h_reg, MAX_HEIGHT));
      p00 = read_pixel(tx.lo, ty.lo);
      p01 = read_pixel(tx.hi, ty.lo);
      p10 = read_pixel(tx.lo, ty.hi);
      p11 = read_pixel(tx.hi, ty.hi);
      nch = (ccnt_reg > 4) ? 4 : int'(ccnt_reg);
      for (int c = 0; c < 4; c++) begin
         if (c >= nch) begin
            ch[c] = 8'h00;
         end else begin
            sh = 8 * c;
            a = int'((p00 >> sh) & 32'hFF) * (256 - tx.wt) + int'((p01 >> sh) & 32'hFF) * tx.wt;
            b = int'((p10 >> sh) & 32'hFF) * (256 - tx.wt) + int'((p11 >> sh) & 32'hFF) * tx.wt;
            v = (a * (256 - ty.wt) + b * ty.wt + 32768) >> 16;
            ch[c] = (v > 255) ? 8'hFF : v[7:0];
         end
      end
      r.out_ch0 = ch[0];
      r.out_ch1 = ch[1];
      r.out_ch2 = ch[2];
      r.out_ch3 = ch[3];
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      bis_pkg::rsp_type want;
      int               x, y;
      if (reset) begin
         src_w_reg = 10'd512;
         src_h_reg = 10'd512;
         dst_w_reg = 10'd512;
         dst_h_reg = 10'd512;
         ccnt_reg  = 3'd4;
         expected_pixels.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t: result %h with no request outstanding", $time, rsp_data);
            end else begin
               want = expected_pixels.pop_front();
               checked++;
               compare_field("out_ch0", want.out_ch0, rsp_data.out_ch0);
               compare_field("out_ch1", want.out_ch1, rsp_data.out_ch1);
               compare_field("out_ch2", want.out_ch2, rsp_data.out_ch2);
               compare_field("out_ch3", want.out_ch3, rsp_data.out_ch3);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[bis_pkg::CSR_AW-1:2])
               bis_pkg::REG_SRC_WIDTH:  src_w_reg = pwdata[bis_pkg::SIZE_W-1:0];
               bis_pkg::REG_SRC_HEIGHT: src_h_reg = pwdata[bis_pkg::SIZE_W-1:0];
               bis_pkg::REG_DST_WIDTH:  dst_w_reg = pwdata[bis_pkg::SIZE_W-1:0];
               bis_pkg::REG_DST_HEIGHT: dst_h_reg = pwdata[bis_pkg::SIZE_W-1:0];
               bis_pkg::REG_CHAN_COUNT: ccnt_reg  = pwdata[bis_pkg::CCNT_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            x = int'(req_data.pos_x);
            y = int'(req_data.pos_y);
            if (req_data.kind == bis_pkg::KIND_STORE) begin
               if (x < size_in_use(src_w_reg, MAX_WIDTH) && y < size_in_use(src_h_reg, MAX_HEIGHT))
                  source_copy[y * MAX_WIDTH + x] = {req_data.in_ch3, req_data.in_ch2,
                                                    req_data.in_ch1, req_data.in_ch0};
            end else if (x < size_in_use(dst_w_reg, MAX_WIDTH) &&
                         y < size_in_use(dst_h_reg, MAX_HEIGHT)) begin
               expected_pixels.push_back(resample_pixel(x, y));
            end
         end
      end
      fail_count      <= errors;
      pending         <= expected_pixels.size();
      results_checked <= checked;
   end

endmodule

// ===== tb/bilinear_image_scaler_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the bilinear image scaler: clock, reset, register set-up and request
// stimulus over a series of size settings. Checking is done by
// bilinear_image_scaler_checker; depends on bis_pkg and the scaler RTL.
module bilinear_image_scaler_tb;

   localparam int         MAX_SIZE       = 512;
   localparam int         CYCLE_LIMIT    = 500000;
   localparam int         SETTLE_CYCLES  = 40;
   localparam int         RANDOM_PHASES  = 7;
   localparam int         PHASE_REQUESTS = 30;
   localparam logic [2:0] REG_UNUSED     = 3'd5;

   logic                       clock    = 1'b0;
   logic                       reset    = 1'b1;
   logic                       start    = 1'b0;
   logic                       busy;
   bis_pkg::req_type           req_data = '0;
   logic                       rsp_valid;
   bis_pkg::rsp_type           rsp_data;
   logic                       psel     = 1'b0;
   logic                       penable  = 1'b0;
   logic                       pwrite   = 1'b0;
   logic [bis_pkg::CSR_AW-1:0] paddr    = '0;
   logic [31:0]                pwdata   = '0;
   logic [31:0]                prdata;
   logic                       pready;
   int                         fail_count, pending, results_checked;
   int                         cycle_count = 0;
   int                         src_w, src_h, dst_w, dst_h;
   bit                         steady = 1'b0;
   int                         stores_sent = 0, computes_sent = 0, settings_used = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bilinear_image_scaler uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   bilinear_image_scaler_checker pixel_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int clip_size(int v);
      v = v & 1023;
      if (v == 0) return 1;
      if (v > MAX_SIZE) return MAX_SIZE;
      return v;
   endfunction

   // lower or upper source neighbour of destination coordinate d
   function automatic int tap_index(int d, int s, int dd, bit upper);
      longint n, fl;
      n = longint'(2 * d + 1) * s - dd;
      fl = (n < 0) ? -1 : n / (2 * dd);
      if (upper) fl++;
      if (fl < 0) return 0;
      if (fl > s - 1) return s - 1;
      return int'(fl);
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] upper_noise(int w);
      return ($urandom_range(0, 1) == 1) ? (32'($urandom) << w) : 32'h0;
   endfunction

   function automatic bis_pkg::req_type make_request(logic kind, int x, int y);
      bis_pkg::req_type r;
      r.kind   = kind;
      r.pos_x  = x[8:0];
      r.pos_y  = y[8:0];
      r.in_ch0 = 8'($urandom);
      r.in_ch1 = 8'($urandom);
      r.in_ch2 = 8'($urandom);
      r.in_ch3 = 8'($urandom);
      return r;
   endfunction

   function automatic bis_pkg::req_type random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return make_request(bis_pkg::KIND_STORE, $urandom_range(0, 511), $urandom_range(0, 511));
      if (r < 20)
         return make_request(bis_pkg::KIND_STORE, $urandom_range(0, src_w - 1),
                             $urandom_range(0, src_h - 1));
      if (r < 28)
         return make_request(bis_pkg::KIND_COMPUTE, $urandom_range(0, 511),
                             $urandom_range(0, 511));
      if (r < 40)
         return make_request(bis_pkg::KIND_COMPUTE, $urandom_range(0, 1) * (dst_w - 1),
                             $urandom_range(0, 1) * (dst_h - 1));
      return make_request(bis_pkg::KIND_COMPUTE, $urandom_range(0, dst_w - 1),
                          $urandom_range(0, dst_h - 1));
   endfunction

   task automatic send_request(input bis_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         if (start) start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.kind == bis_pkg::KIND_STORE) stores_sent++;
      else computes_sent++;
   endtask

   task automatic send_pixel(input int x, input int y, input logic [31:0] bytes);
      bis_pkg::req_type r;
      r = make_request(bis_pkg::KIND_STORE, x, y);
      {r.in_ch3, r.in_ch2, r.in_ch1, r.in_ch0} = bytes;
      send_request(r);
   endtask

   task automatic send_compute(input int x, input int y);
      send_request(make_request(bis_pkg::KIND_COMPUTE, x, y));
   endtask

   // drop start and wait until every expected result is back
   task automatic go_idle(input int extra);
      if (start) start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_sizes(input int sw, input int sh, input int dw, input int dh,
                              input int cc);
      go_idle(SETTLE_CYCLES);
      write_reg(bis_pkg::REG_SRC_WIDTH, 32'(sw) | upper_noise(bis_pkg::SIZE_W));
      write_reg(bis_pkg::REG_SRC_HEIGHT, 32'(sh) | upper_noise(bis_pkg::SIZE_W));
      write_reg(bis_pkg::REG_DST_WIDTH, 32'(dw) | upper_noise(bis_pkg::SIZE_W));
      write_reg(bis_pkg::REG_DST_HEIGHT, 32'(dh) | upper_noise(bis_pkg::SIZE_W));
      write_reg(bis_pkg::REG_CHAN_COUNT, 32'(cc) | upper_noise(bis_pkg::CCNT_W));
      write_reg(REG_UNUSED, $urandom);
      src_w = clip_size(sw);
      src_h = clip_size(sh);
      dst_w = clip_size(dw);
      dst_h = clip_size(dh);
      steady = ($urandom_range(0, 3) == 0);
      settings_used++;
   endtask

   // every source pixel that a compute can reach is written first
   task automatic run_phase();
      bit col_used [MAX_SIZE];
      bit row_used [MAX_SIZE];
      for (int i = 0; i < MAX_SIZE; i++) begin
         col_used[i] = 1'b0;
         row_used[i] = 1'b0;
      end
      for (int d = 0; d < dst_w; d++) begin
         col_used[tap_index(d, src_w, dst_w, 1'b0)] = 1'b1;
         col_used[tap_index(d, src_w, dst_w, 1'b1)] = 1'b1;
      end
      for (int d = 0; d < dst_h; d++) begin
         row_used[tap_index(d, src_h, dst_h, 1'b0)] = 1'b1;
         row_used[tap_index(d, src_h, dst_h, 1'b1)] = 1'b1;
      end
      for (int y = 0; y < src_h; y++)
         for (int x = 0; x < src_w; x++)
            if (row_used[y] && col_used[x])
               send_request(make_request(bis_pkg::KIND_STORE, x, y));
      repeat (PHASE_REQUESTS) begin
         send_request(random_request());
         if ($urandom_range(0, 99) == 0) go_idle(0);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2 source up to 5x3: extreme bytes, edges, requests off the image
      apply_sizes(2, 2, 5, 3, 4);
      send_pixel(0, 0, 32'h0180_00FF);
      send_pixel(1, 0, 32'hFE7F_FF00);
      send_pixel(0, 1, 32'hFFFF_FFFF);
      send_pixel(1, 1, 32'h0000_0000);
      send_pixel(2, 0, 32'h5555_5555);
      send_pixel(511, 0, 32'hAAAA_AAAA);
      send_pixel(0, 511, 32'hFFFF_FFFF);
      send_pixel(511, 511, 32'h0000_0000);
      send_compute(0, 0);
      send_compute(4, 0);
      send_compute(0, 2);
      send_compute(4, 2);
      send_compute(2, 1);
      send_compute(3, 1);
      send_compute(1, 2);
      send_compute(5, 0);
      send_compute(0, 3);
      send_compute(511, 511);
      go_idle(0);
      send_compute(1, 1);

      apply_sizes(1, 1, 1, 1, 1);
      run_phase();
      apply_sizes(1023, 1, 3, 2, 4);
      run_phase();
      apply_sizes(1, 512, 7, 9, 0);
      run_phase();
      apply_sizes(0, 9, 1023, 0, 5);
      run_phase();
      apply_sizes(5, 4, 13, 11, 2);
      run_phase();
      apply_sizes(16, 16, 5, 5, 3);
      run_phase();
      apply_sizes(2, 2, 512, 512, 7);
      run_phase();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_sizes($urandom_range(1, 8), $urandom_range(1, 8),
                     ($urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : $urandom_range(1, 512),
                     ($urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : $urandom_range(1, 512),
                     $urandom_range(0, 7));
         run_phase();
      end

      go_idle(SETTLE_CYCLES);
      $display("Ran %0d size settings with %0d stores and %0d computes accepted;",
               settings_used, stores_sent, computes_sent);
      $display("%0d resampled pixels compared, %0d mismatches.", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== bilinear_image_scaler.f =====
+incdir+hdl
hdl/bis_pkg.sv
hdl/bis_ram.sv
hdl/bilinear_image_scaler.sv
hdl/bis_check.sv
tb/bilinear_image_scaler_checker.sv
tb/bilinear_image_scaler_tb.sv
